/* rtl/cjs_pkg.sv */
// package: shared constants and types for the cpu job scheduler
package cjs_pkg;
    localparam int MAX_JOBS_DEF = 16;
    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_SRTF = 3'd2;
    localparam logic [2:0] POL_RR   = 3'd3;
    localparam logic [2:0] POL_PRIO = 3'd4;
    localparam logic [0:0] CFG_POLICY  = 1'd0;
    localparam logic [0:0] CFG_QUANTUM = 1'd1;
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam int SLOT_W = 8 + 16 + 16 + 8 + 16 + 1;

    typedef struct packed {
        logic        action;
        logic [7:0]  job_id;
        logic [15:0] job_burst;
        logic [7:0]  job_priority;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        ran;
        logic [7:0]  run_id;
        logic        first_dispatch;
        logic        finished;
        logic [15:0] slice_start;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] left;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] order;
        logic        started;
    } t_slot;
endpackage

/* rtl/cjs_req_if.sv */
// interface: request channel
interface cjs_req_if
    import cjs_pkg::*;
();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/cjs_rsp_if.sv */
// interface: result channel
interface cjs_rsp_if
    import cjs_pkg::*;
();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/cjs_ram.sv */
// generic simple dual port ram (one write port, one read port) with registered read
module cjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/cpu_job_scheduler.sv */
// top level: cpu job scheduler with slot table in ram
// usage:
// requests enter on the i_req channel (valid/ready), one result per request
// leaves on o_rsp. an arrive request has its result in the cycle after it is
// taken; a tick request scans all MAX_JOBS slots from the slot ram, one read
// per cycle, then a read-modify-write of the chosen slot, if any; the scan is
// skipped when the running job keeps the cpu (fcfs, sjf, round robin inside
// its slice). the single ram read port forces the scan to be serial. one
// request is in work at a time; the result sits in an output register until
// taken, and the next request is taken once that register is free or being
// emptied.
// reset (synchronous, active low) clears valid bits, running slot, counters
// and config (policy fcfs, quantum 2); slot ram contents are left alone and
// are never used before being written. a stalled receiver holds the result
// and blocks further requests. config writes go on i_cfg_* when idle.
module cpu_job_scheduler
    import cjs_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    cjs_req_if.sink     i_req,
    cjs_rsp_if.source   o_rsp
);
    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_LAST = 4'd2,
                           S_RD = 4'd3, S_UPD = 4'd4, S_OUT = 4'd5,
                           S_CUR = 4'd6;

    logic [3:0]          r_state;
    logic [MAX_JOBS-1:0] r_valid;
    logic [2:0]          r_policy;
    logic [7:0]          r_quantum;
    logic                r_run_ok;
    logic [AW-1:0]       r_run;
    logic [7:0]          r_slice;
    logic [15:0]         r_time, r_next;
    t_rsp                r_rsp;
    logic                r_rsp_v;
    logic [CW-1:0]       r_cnt;
    logic [AW-1:0]       r_cidx;
    logic                r_best_ok;
    logic [AW-1:0]       r_best;
    logic [15:0]         r_bkey, r_bage;
    logic [2:0]          r_p;
    logic                r_cur_ok;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_slot         wdata, rdata;

    cjs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_JOBS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic          take;
    logic          free_ok;
    logic [AW-1:0] free_idx;
    logic [2:0]    pol;
    logic [7:0]    qnt;
    logic          cur_ok;
    logic [15:0]   key, age;
    logic          better;
    logic [15:0]   left_m1;
    logic          arrive_ok;
    logic          keep_cur;
    logic          rsp_set;

    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_v || o_rsp.ready);
    assign take = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data = r_rsp;
    assign pol = (r_policy > POL_PRIO) ? POL_FCFS : r_policy;
    assign qnt = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign cur_ok = r_run_ok && r_valid[r_run];
    assign left_m1 = rdata.left - 16'd1;
    assign arrive_ok = (i_req.data.job_burst != 16'd0) && free_ok;
    assign keep_cur = r_cur_ok && ((r_p == POL_FCFS || r_p == POL_SJF) ||
                                   (r_p == POL_RR && r_slice < qnt));

    always_comb begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        unique case (r_p)
            POL_SJF:  key = rdata.burst;
            POL_SRTF: key = rdata.left;
            POL_PRIO: key = {8'd0, rdata.prio};
            default:  key = 16'd0;
        endcase
        age = r_next - rdata.order;
        better = !r_best_ok || key < r_bkey || (key == r_bkey && age > r_bage);
    end

    always_comb begin
        rsp_set = 1'b0;
        unique case (r_state)
            S_IDLE: rsp_set = take && i_req.data.action == ACT_ARRIVE;
            S_LAST: rsp_set = !(r_valid[r_cidx] && better) && !r_best_ok;
            S_UPD:  rsp_set = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        we = 1'b0;
        waddr = r_best;
        wdata = rdata;
        raddr = AW'(r_cnt - CW'(1));
        unique case (r_state)
            S_IDLE: begin
                raddr = r_run;
                if (take && i_req.data.action == ACT_ARRIVE && arrive_ok) begin
                    we = 1'b1;
                    waddr = free_idx;
                    wdata.ident = i_req.data.job_id;
                    wdata.left = i_req.data.job_burst;
                    wdata.burst = i_req.data.job_burst;
                    wdata.prio = i_req.data.job_priority;
                    wdata.order = r_next;
                    wdata.started = 1'b0;
                end
            end
            S_CUR: begin
                raddr = r_run;
                if (r_p == POL_RR && r_cur_ok && r_slice >= qnt) begin
                    we = 1'b1;
                    waddr = r_run;
                    wdata = rdata;
                    wdata.order = r_next;
                end
            end
            S_RD: raddr = r_best;
            S_UPD: begin
                we = 1'b1;
                waddr = r_best;
                wdata = rdata;
                wdata.started = 1'b1;
                wdata.left = left_m1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_policy <= POL_FCFS;
            r_quantum <= 8'd2;
            r_run_ok <= 1'b0;
            r_run <= '0;
            r_slice <= 8'd0;
            r_time <= 16'd0;
            r_next <= 16'd0;
            r_rsp_v <= 1'b0;
            r_cnt <= '0;
            r_best_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLICY:  r_policy <= i_cfg_data[2:0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    default: ;
                endcase
            end
            if (rsp_set) r_rsp_v <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_rsp_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_req.data.action == ACT_ARRIVE) begin
                            r_rsp <= {arrive_ok, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0};
                            if (arrive_ok) begin
                                r_valid[free_idx] <= 1'b1;
                                r_next <= r_next + 16'd1;
                            end
                        end else begin
                            r_rsp <= {1'b0, 1'b0, 8'd0, 1'b0, 1'b0, r_time};
                            r_p <= pol;
                            r_cur_ok <= cur_ok;
                            r_time <= r_time + 16'd1;
                            r_state <= S_CUR;
                        end
                    end
                end
                S_CUR: begin
                    r_best <= r_run;
                    if (keep_cur) begin
                        r_best_ok <= 1'b1;
                        r_state <= S_RD;
                    end else begin
                        r_best_ok <= 1'b0;
                        if (r_p == POL_RR && r_cur_ok) begin
                            r_next <= r_next + 16'd1;
                            r_cur_ok <= 1'b0;
                        end
                        r_cnt <= CW'(1);
                        r_cidx <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt != CW'(1) && r_valid[r_cidx] && better) begin
                        r_best_ok <= 1'b1;
                        r_best <= r_cidx;
                        r_bkey <= key;
                        r_bage <= age;
                    end
                    if (r_cnt != CW'(1)) r_cidx <= r_cidx + AW'(1);
                    if (r_cnt == CW'(MAX_JOBS)) r_state <= S_LAST;
                    else r_cnt <= r_cnt + CW'(1);
                end
                S_LAST: begin
                    if (r_valid[r_cidx] && better) begin
                        r_best_ok <= 1'b1;
                        r_best <= r_cidx;
                        r_bkey <= key;
                        r_bage <= age;
                        r_state <= S_RD;
                    end else if (r_best_ok) begin
                        r_state <= S_RD;
                    end else begin
                        r_run_ok <= 1'b0;
                        r_slice <= 8'd0;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    r_rsp.ran <= 1'b1;
                    r_rsp.run_id <= rdata.ident;
                    r_rsp.first_dispatch <= !rdata.started;
                    if (left_m1 == 16'd0) begin
                        r_rsp.finished <= 1'b1;
                        r_valid[r_best] <= 1'b0;
                        r_run_ok <= 1'b0;
                        r_slice <= 8'd0;
                    end else begin
                        if (r_cur_ok && r_best == r_run) begin
                            if (r_slice != 8'hFF) r_slice <= r_slice + 8'd1;
                        end else begin
                            r_slice <= 8'd1;
                        end
                        r_run_ok <= 1'b1;
                        r_run <= r_best;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* tb/sv/cjs_sched_checker.sv */
// checker: predicts scheduler results from observed requests and compares them
`timescale 1ns / 1ps
module cjs_sched_checker
    import cjs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_req_fire,
    input  t_req        i_req_data,
    input  logic        i_rsp_fire,
    input  t_rsp        i_rsp_data,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NJ = MAX_JOBS_DEF;
    localparam logic [7:0] NONE = 8'hFF;

    logic        j_valid [NJ];
    logic [7:0]  j_ident [NJ];
    logic [15:0] j_left [NJ];
    logic [15:0] j_burst [NJ];
    logic [7:0]  j_prio [NJ];
    logic [15:0] j_order [NJ];
    logic        j_started [NJ];
    logic [7:0]  run_slot;
    logic [7:0]  slice_cnt;
    logic [15:0] now_count;
    logic [15:0] order_next;
    logic [2:0]  pol_reg;
    logic [7:0]  quantum_reg;
    t_rsp        expected_rsps[$];

    function automatic logic [15:0] rank_key(int s, logic [2:0] p);
        if (p == POL_SJF) return j_burst[s];
        if (p == POL_SRTF) return j_left[s];
        if (p == POL_PRIO) return {8'd0, j_prio[s]};
        return 16'd0;
    endfunction

    function automatic logic [7:0] choose_slot(logic [2:0] p);
        logic [7:0] best;
        logic [15:0] ks, kb;
        best = NONE;
        for (int s = 0; s < NJ; s++) begin
            if (j_valid[s]) begin
                if (best == NONE) begin
                    best = s[7:0];
                end else begin
                    ks = rank_key(s, p);
                    kb = rank_key(best, p);
                    if (ks < kb || (ks == kb &&
                        16'(order_next - j_order[s]) > 16'(order_next - j_order[best])))
                        best = s[7:0];
                end
            end
        end
        return best;
    endfunction

    task automatic schedule_request(input t_req r);
        t_rsp o;
        logic [7:0] fs, cur, ch;
        logic [2:0] p;
        logic [7:0] q;
        o = '0;
        if (r.action == ACT_ARRIVE) begin
            fs = NONE;
            if (r.job_burst != 0)
                for (int s = NJ - 1; s >= 0; s--)
                    if (!j_valid[s]) fs = s[7:0];
            if (fs != NONE) begin
                j_valid[fs] = 1'b1;
                j_ident[fs] = r.job_id;
                j_left[fs] = r.job_burst;
                j_burst[fs] = r.job_burst;
                j_prio[fs] = r.job_priority;
                j_order[fs] = order_next;
                j_started[fs] = 1'b0;
                order_next++;
                o.accepted = 1'b1;
            end
        end else begin
            o.slice_start = now_count;
            now_count++;
            p = (pol_reg > POL_PRIO) ? POL_FCFS : pol_reg;
            q = (quantum_reg == 0) ? 8'd1 : quantum_reg;
            cur = run_slot;
            if (cur >= NJ || !j_valid[cur]) cur = NONE;
            if ((p == POL_FCFS || p == POL_SJF) && cur != NONE) begin
                ch = cur;
            end else if (p == POL_RR) begin
                if (cur != NONE && slice_cnt < q) begin
                    ch = cur;
                end else begin
                    if (cur != NONE) begin
                        j_order[cur] = order_next;
                        order_next++;
                        cur = NONE;
                    end
                    ch = choose_slot(POL_FCFS);
                end
            end else begin
                ch = choose_slot(p);
            end
            if (ch == NONE) begin
                run_slot = NONE;
                slice_cnt = 0;
            end else begin
                o.ran = 1'b1;
                o.run_id = j_ident[ch];
                o.first_dispatch = !j_started[ch];
                j_started[ch] = 1'b1;
                j_left[ch]--;
                if (j_left[ch] == 0) begin
                    o.finished = 1'b1;
                    j_valid[ch] = 1'b0;
                    run_slot = NONE;
                    slice_cnt = 0;
                end else begin
                    if (ch == cur && slice_cnt < 8'hFF) slice_cnt++;
                    else if (ch != cur) slice_cnt = 1;
                    run_slot = ch;
                end
            end
        end
        expected_rsps.push_back(o);
    endtask

    task automatic compare_rsp(input t_rsp a);
        t_rsp e;
        if (expected_rsps.size() == 0) begin
            $error("unexpected result %p", a);
            o_fail_count++;
            return;
        end
        e = expected_rsps.pop_front();
        if (a.accepted !== e.accepted) begin
            $error("accepted exp %0d got %0d", e.accepted, a.accepted);
            o_fail_count++;
        end
        if (a.ran !== e.ran) begin
            $error("ran exp %0d got %0d", e.ran, a.ran);
            o_fail_count++;
        end
        if (a.run_id !== e.run_id) begin
            $error("run_id exp %0d got %0d", e.run_id, a.run_id);
            o_fail_count++;
        end
        if (a.first_dispatch !== e.first_dispatch) begin
            $error("first_dispatch exp %0d got %0d", e.first_dispatch, a.first_dispatch);
            o_fail_count++;
        end
        if (a.finished !== e.finished) begin
            $error("finished exp %0d got %0d", e.finished, a.finished);
            o_fail_count++;
        end
        if (a.slice_start !== e.slice_start) begin
            $error("slice_start exp %0d got %0d", e.slice_start, a.slice_start);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_rsps.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NJ; s++) j_valid[s] = 1'b0;
            run_slot = NONE;
            slice_cnt = 0;
            now_count = 0;
            order_next = 0;
            pol_reg = POL_FCFS;
            quantum_reg = 8'd2;
            expected_rsps.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_POLICY) pol_reg = i_cfg_data[2:0];
                else quantum_reg = i_cfg_data;
            end
            if (i_rsp_fire) compare_rsp(i_rsp_data);
            if (i_req_fire) schedule_request(i_req_data);
        end
    end
endmodule

/* tb/sv/cpu_job_scheduler_test.sv */
// testbench top: drives requests and config, stalls results, gives the verdict
`timescale 1ns / 1ps
module cpu_job_scheduler_test;
    import cjs_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    int         fail_count;
    int         pending;
    int         cycle_count;
    bit         hold_rsp;
    bit         stim_done;

    cjs_req_if req_ch ();
    cjs_rsp_if rsp_ch ();

    cpu_job_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    cjs_sched_checker checker_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_fire(req_ch.valid && req_ch.ready), .i_req_data(req_ch.data),
        .i_rsp_fire(rsp_ch.valid && rsp_ch.ready), .i_rsp_data(rsp_ch.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(input t_req r);
        int g;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g != 0) begin
            req_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic arrive(input logic [7:0] id, input logic [15:0] b, input logic [7:0] p);
        t_req r;
        r.action = ACT_ARRIVE;
        r.job_id = id;
        r.job_burst = b;
        r.job_priority = p;
        send_request(r);
    endtask

    task automatic tick();
        t_req r;
        r = '0;
        r.action = ACT_TICK;
        r.job_id = 8'($urandom);
        r.job_burst = 16'($urandom);
        r.job_priority = 8'($urandom);
        send_request(r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [7:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_burst();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(1, 20));
            default: return 16'($urandom_range(1, 5));
        endcase
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rsp) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [7:0] qv;
        cycle_count = 0;
        stim_done = 0;
        hold_rsp = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle tick, zero burst, extremes, fill table
        tick();
        arrive(8'd0, 16'd0, 8'd0);
        arrive(8'hFF, 16'd3, 8'hFF);
        arrive(8'h00, 16'd1, 8'h00);
        for (int k = 0; k < 15; k++) arrive(8'(k + 16), 16'd2, 8'(k));
        for (int k = 0; k < 6; k++) tick();
        write_cfg(CFG_POLICY, 8'(POL_RR));
        write_cfg(CFG_QUANTUM, 8'd0);
        for (int k = 0; k < 4; k++) tick();
        write_cfg(CFG_QUANTUM, 8'hFF);

        // long receiver stall while requests keep coming
        fork
            begin
                hold_rsp = 1;
                repeat (300) @(negedge i_clk);
                hold_rsp = 0;
            end
            for (int k = 0; k < 10; k++) tick();
        join

        for (int ph = 0; ph < 12; ph++) begin
            write_cfg(CFG_POLICY, 8'((ph == 11) ? 3'd7 : 3'(ph % 6)));
            qv = (ph % 4 == 0) ? 8'd1 : (ph % 4 == 1) ? 8'hFF : 8'($urandom_range(1, 4));
            write_cfg(CFG_QUANTUM, qv);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(0, 9) < 4) arrive(8'($urandom), rand_burst(), 8'($urandom));
                else tick();
            end
            if (ph == 5) drain();
        end
        // let leftover long jobs be visible but bounded
        stim_done = 1;
        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
